// ===== rtl/call_list_table_lookup_unit_macros.svh =====
// Assertion shorthands for the call list lookup unit.
`ifndef CALL_LIST_TABLE_LOOKUP_UNIT_MACROS_SVH
`define CALL_LIST_TABLE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLTL_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLTL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/cltl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cltl_pkg;

    localparam int MAX_METHODS = 64;
    localparam int MAX_ENTRIES = 4096;

    // Field and register widths
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 12;
    localparam int HASH_W = 32;
    localparam int MC_W   = 7;
    localparam int CNT_W  = 13;
    localparam int SL_W   = 13;
    localparam int CI_W   = 6;

    // Store addressing
    localparam int MADDR_W = $clog2(MAX_METHODS);
    localparam int EADDR_W = $clog2(MAX_ENTRIES);
    // Running slice position: sum of all counts plus one more count
    localparam int POS_W   = $clog2(MAX_METHODS * MAX_ENTRIES + MAX_ENTRIES + 1);

    // Loaded counts saturate here
    localparam int CNT_LIMIT = (MAX_ENTRIES < 8191) ? MAX_ENTRIES : 8191;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_COUNT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_HASH  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CALLEE     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CALLER     = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/cltl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cltl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/call_list_table_lookup_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Loads and out-of-range queries: one result on the cycle after the transfer, busy never rises.
// Callee query: a count sweep from method 0 up to the index, then one result as busy falls.
// Caller query: per method a count read, up to ceil(log2(count + 1)) probes and a check read;
//   empty or skipped slices take the count read only. The closing state S_KDONE ends the scan.
// Throughput is set by the single read port of each store; results cannot be stalled.
// Synchronous active-low reset clears the sequencer, strobe and method_count; stores stay undefined.

`include "call_list_table_lookup_unit_macros.svh"

module call_list_table_lookup_unit
    import cltl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [MC_W-1:0]   i_cfg_wdata,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [IDX_W-1:0]  i_item_index,
    input  wire logic [HASH_W-1:0] i_item_value,
    output logic                   o_valid,
    output logic [SL_W-1:0]        o_slice_start,
    output logic [SL_W-1:0]        o_slice_length,
    output logic [CI_W-1:0]        o_caller_index,
    output logic                   o_found,
    output logic                   o_run_last,
    output logic                   o_fault
);

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a transfer
    localparam logic [2:0] S_CQ    = 3'd1;  // callee sweep, count data valid
    localparam logic [2:0] S_KCNT  = 3'd2;  // caller scan, count data valid
    localparam logic [2:0] S_KSRCH = 3'd3;  // binary search probe data valid
    localparam logic [2:0] S_KFIN  = 3'd4;  // lower-bound entry data valid
    localparam logic [2:0] S_KDONE = 3'd5;  // emit the closing caller result

    logic [2:0]         r_state, n_state;
    logic [MC_W-1:0]    r_method_count;
    logic [MADDR_W-1:0] r_m, n_m;
    logic [MADDR_W-1:0] r_tgt, n_tgt;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [HASH_W-1:0]  r_val, n_val;
    logic [SL_W-1:0]    r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_end, n_end;
    logic               r_kfault, n_kfault;
    logic               r_pend_vld, n_pend_vld;
    logic [CI_W-1:0]    r_pend_idx, n_pend_idx;

    // Result register
    logic               r_valid, n_valid;
    logic [SL_W-1:0]    r_start, n_start, r_len, n_len;
    logic [CI_W-1:0]    r_caller, n_caller;
    logic               r_found, n_found, r_last, n_last, r_fault, n_fault;

    // Store ports
    logic               cnt_we;
    logic [MADDR_W-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic               hash_we;
    logic [EADDR_W-1:0] hash_waddr, hash_raddr;
    logic [HASH_W-1:0]  hash_wdata, hash_rdata;

    // Working values
    logic [MC_W-1:0]    eff_n;
    logic               accept;
    logic               do_adv;
    logic [POS_W-1:0]   sum_pos;
    logic [POS_W-1:0]   clip_start;
    logic [SL_W-1:0]    s_lo, s_hi;
    logic               lt;

    cltl_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_METHODS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    cltl_ram #(
        .WIDTH (HASH_W),
        .DEPTH (MAX_ENTRIES)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (hash_we),
        .i_waddr (hash_waddr),
        .i_wdata (hash_wdata),
        .i_raddr (hash_raddr),
        .o_rdata (hash_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Methods in use, capped at the table depth
    assign eff_n = (r_method_count > MC_W'(MAX_METHODS)) ? MC_W'(MAX_METHODS) : r_method_count;

    always_comb begin
        n_state    = r_state;
        n_m        = r_m;
        n_tgt      = r_tgt;
        n_pos      = r_pos;
        n_val      = r_val;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_end      = r_end;
        n_kfault   = r_kfault;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;

        n_valid  = 1'b0;
        n_start  = r_start;
        n_len    = r_len;
        n_caller = r_caller;
        n_found  = r_found;
        n_last   = r_last;
        n_fault  = r_fault;

        cnt_we     = 1'b0;
        cnt_waddr  = i_item_index[MADDR_W-1:0];
        cnt_wdata  = (i_item_value > 32'(CNT_LIMIT)) ? CNT_W'(CNT_LIMIT)
                                                      : i_item_value[CNT_W-1:0];
        cnt_raddr  = r_m;
        hash_we    = 1'b0;
        hash_waddr = i_item_index[EADDR_W-1:0];
        hash_wdata = i_item_value;
        hash_raddr = r_mid[EADDR_W-1:0];

        do_adv     = 1'b0;
        sum_pos    = r_pos + POS_W'(cnt_rdata);
        clip_start = (r_pos > POS_W'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : r_pos;
        lt         = (hash_rdata < r_val);
        s_lo       = lt ? (r_mid + SL_W'(1)) : r_lo;
        s_hi       = lt ? r_hi : r_mid;

        unique case (r_state)
            S_IDLE: begin
                cnt_raddr = '0;
                if (accept) begin
                    // Default result: plain closing transfer with last set and everything else zero
                    n_valid  = 1'b1;
                    n_start  = '0;
                    n_len    = '0;
                    n_caller = '0;
                    n_found  = 1'b0;
                    n_last   = 1'b1;
                    n_fault  = 1'b0;
                    unique case (i_req_type)
                        REQ_LOAD_COUNT: begin
                            if (32'(i_item_index) < 32'(MAX_METHODS)) begin
                                cnt_we = 1'b1;
                            end else begin
                                n_fault = 1'b1;
                            end
                        end
                        REQ_LOAD_HASH: begin
                            if (32'(i_item_index) < 32'(MAX_ENTRIES)) begin
                                hash_we = 1'b1;
                            end else begin
                                n_fault = 1'b1;
                            end
                        end
                        REQ_CALLEE: begin
                            if (32'(i_item_index) >= 32'(eff_n)) begin
                                n_fault = 1'b1;
                            end else begin
                                // Hold the result; sweep counts from method 0
                                n_valid = 1'b0;
                                n_tgt   = i_item_index[MADDR_W-1:0];
                                n_m     = '0;
                                n_pos   = '0;
                                n_state = S_CQ;
                            end
                        end
                        REQ_CALLER: begin
                            if (eff_n != '0) begin
                                n_valid    = 1'b0;
                                n_val      = i_item_value;
                                n_m        = '0;
                                n_pos      = '0;
                                n_kfault   = 1'b0;
                                n_pend_vld = 1'b0;
                                n_state    = S_KCNT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_CQ: begin
                if (r_m == r_tgt) begin
                    n_valid  = 1'b1;
                    n_caller = '0;
                    n_found  = 1'b0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    if (cnt_rdata == '0) begin
                        n_start = '0;
                        n_len   = '0;
                        n_fault = 1'b0;
                    end else if (sum_pos > POS_W'(MAX_ENTRIES)) begin
                        // Clip the slice to the store
                        n_start = SL_W'(clip_start);
                        n_len   = SL_W'(POS_W'(MAX_ENTRIES) - clip_start);
                        n_fault = 1'b1;
                    end else begin
                        n_start = SL_W'(r_pos);
                        n_len   = SL_W'(cnt_rdata);
                        n_fault = 1'b0;
                    end
                end else begin
                    n_pos     = sum_pos;
                    n_m       = r_m + MADDR_W'(1);
                    cnt_raddr = r_m + MADDR_W'(1);
                end
            end

            S_KCNT: begin
                n_pos = sum_pos;
                if (cnt_rdata == '0) begin
                    do_adv = 1'b1;
                end else if (sum_pos > POS_W'(MAX_ENTRIES)) begin
                    // Skip a slice that runs past the store
                    n_kfault = 1'b1;
                    do_adv   = 1'b1;
                end else begin
                    n_lo       = SL_W'(r_pos);
                    n_hi       = SL_W'(sum_pos);
                    n_end      = SL_W'(sum_pos);
                    n_mid      = SL_W'(r_pos) + (cnt_rdata >> 1);
                    hash_raddr = n_mid[EADDR_W-1:0];
                    n_state    = S_KSRCH;
                end
            end

            S_KSRCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (s_lo < s_hi) begin
                    n_mid      = s_lo + ((s_hi - s_lo) >> 1);
                    hash_raddr = n_mid[EADDR_W-1:0];
                end else if (s_lo < r_end) begin
                    // Fetch the lower-bound entry for the equality check
                    n_mid      = s_lo;
                    hash_raddr = s_lo[EADDR_W-1:0];
                    n_state    = S_KFIN;
                end else begin
                    do_adv = 1'b1;
                end
            end

            S_KFIN: begin
                if (hash_rdata == r_val) begin
                    // Release the previous match; hold this one until the next match or the end of the scan
                    if (r_pend_vld) begin
                        n_valid  = 1'b1;
                        n_start  = '0;
                        n_len    = '0;
                        n_caller = r_pend_idx;
                        n_found  = 1'b1;
                        n_last   = 1'b0;
                        n_fault  = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_idx = CI_W'(r_m);
                end
                do_adv = 1'b1;
            end

            S_KDONE: begin
                n_valid  = 1'b1;
                n_start  = '0;
                n_len    = '0;
                n_caller = r_pend_vld ? r_pend_idx : '0;
                n_found  = r_pend_vld;
                n_last   = 1'b1;
                n_fault  = r_kfault;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance the caller scan to the next method or close it
        if (do_adv) begin
            if ((MC_W'(r_m) + MC_W'(1)) == eff_n) begin
                n_state = S_KDONE;
            end else begin
                n_m       = r_m + MADDR_W'(1);
                cnt_raddr = r_m + MADDR_W'(1);
                n_state   = S_KCNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_method_count <= '0;
            r_valid        <= 1'b0;
            r_pend_vld     <= 1'b0;
            r_kfault       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_pend_vld <= n_pend_vld;
            r_kfault   <= n_kfault;
            if (i_cfg_we) begin
                r_method_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_tgt      <= n_tgt;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_end      <= n_end;
        r_pend_idx <= n_pend_idx;
        r_start    <= n_start;
        r_len      <= n_len;
        r_caller   <= n_caller;
        r_found    <= n_found;
        r_last     <= n_last;
        r_fault    <= n_fault;
    end

    assign o_valid        = r_valid;
    assign o_slice_start  = r_start;
    assign o_slice_length = r_len;
    assign o_caller_index = r_caller;
    assign o_found        = r_found;
    assign o_run_last     = r_last;
    assign o_fault        = r_fault;

    // Every transfer either closes on the next cycle or starts a busy run
    `CLTL_ASSERT_NEXT(a_accept_acts, accept, busy || o_valid, "transfer left no trace")
    // Leaving a run always hands out its closing result
    `CLTL_ASSERT_NEXT(a_fall_last, busy && (n_state == S_IDLE), o_valid && o_run_last,
        "run ended without result")
    // Non-final results are only released caller matches in mid scan
    `CLTL_ASSERT_NOW(a_mid_match, o_valid && !o_run_last, busy && o_found && !o_fault,
        "stray intermediate result")
    // Search window stays nonempty and inside the slice
    `CLTL_ASSERT_NOW(a_window, r_state == S_KSRCH, r_lo < r_hi && r_hi <= r_end,
        "search window broken")

endmodule

`default_nettype wire
